/* src/bb3_pkg.sv */
// Package for the 3x3 edge-aware box blur.
// Holds the payload and job structs and the size constants; no dependencies.
package bb3_pkg;

	localparam int MaxWidth = 1024;
	localparam int ColW     = $clog2(MaxWidth);
	localparam int AddrW    = $clog2(3 * MaxWidth);
	localparam int QDepth   = 4;
	localparam int QPtrW    = $clog2(QDepth);

	typedef enum logic [0:0] {
		CFG_WIDTH  = 1'b0,
		CFG_HEIGHT = 1'b1
	} cfg_idx_t;

	typedef struct packed {
		logic       cmd;
		logic [7:0] in_red;
		logic [7:0] in_green;
		logic [7:0] in_blue;
	} in_item_t;

	typedef struct packed {
		logic [7:0]  out_red;
		logic [7:0]  out_green;
		logic [7:0]  out_blue;
		logic [15:0] out_row;
		logic [9:0]  out_col;
		logic        frame_last;
	} out_item_t;

	// One blur job handed from the front end to the back end.
	typedef struct packed {
		logic [15:0] row;      // centre row
		logic [9:0]  col;      // centre column
		logic [15:0] lim;      // highest row that may be read
		logic        last;
	} job_t;

	// Row slot of row r in the line store (r mod 3), done by reciprocal.
	function automatic logic [1:0] slot3(input logic [16:0] r);
		logic [35:0] p;
		logic [16:0] q;
		logic [16:0] rem;
		begin
			p   = 36'(r) * 36'd43691;
			q   = 17'(p >> 17);
			rem = r - 17'(q * 17'd3);
			if (rem >= 17'd3)
				rem = rem - 17'd3;
			slot3 = rem[1:0];
		end
	endfunction

endpackage

/* src/bb3_front.sv */
// Front end of the box blur: accepts items, writes pixels to the line store
// and issues blur jobs. Depends on bb3_pkg.
module bb3_front import bb3_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  in_item_t          item,
	input  logic [10:0]       eff_w,
	input  logic [15:0]       eff_h,
	output logic              wr_en,
	output logic [AddrW-1:0]  wr_addr,
	output logic [23:0]       wr_data,
	output logic              job_valid,
	output job_t              job,
	input  logic              job_room,
	input  logic              busy
);

	logic [15:0] row_q;
	logic [9:0]  col_q;
	logic [10:0] drain_q;
	logic        done_q;
	logic        second_q;   // second job of a row end still to issue
	job_t        second_job_q;
	logic [15:0] i;
	logic [9:0]  j;
	logic        acc, is_drain, j_last;
	logic [1:0]  slot;

	// an item at column 0 waits for an idle back end: the row slot it may
	// overwrite is still read by jobs of the row two above
	assign full = second_q | ~job_room | (busy & (j == 10'd0));
	assign acc  = push & ~full;
	assign is_drain = item.cmd;

	always_comb begin
		i = done_q ? 16'd0 : row_q;
		j = done_q ? 10'd0 : col_q;
	end
	assign j_last = {1'b0, j} >= eff_w - 11'd1;
	assign slot = slot3({1'b0, i});

	assign wr_en   = acc & ~is_drain;
	assign wr_addr = AddrW'({slot, j});
	assign wr_data = {item.in_red, item.in_green, item.in_blue};

	always_comb begin
		job_valid = 1'b0;
		job = second_job_q;
		if (second_q) begin
			job_valid = 1'b1;
		end else if (acc) begin
			if (is_drain) begin
				if (done_q && drain_q < eff_w) begin
					job_valid = 1'b1;
					job.row = row_q;
					job.col = drain_q[9:0];
					job.lim = row_q;
					job.last = drain_q == eff_w - 11'd1;
				end
			end else if (i != 16'd0) begin
				job.row = i - 16'd1;
				job.lim = i;
				job.last = 1'b0;
				if (j != 10'd0) begin
					job_valid = 1'b1;
					job.col = j - 10'd1;
				end else if (j_last) begin
					job_valid = 1'b1;
					job.col = j;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
			drain_q <= '0;
			done_q <= 1'b0;
			second_q <= 1'b0;
		end else begin
			if (second_q)
				second_q <= 1'b0;
			if (acc) begin
				if (is_drain) begin
					if (done_q && drain_q < eff_w)
						drain_q <= drain_q + 11'd1;
				end else begin
					if (done_q) begin
						done_q <= 1'b0;
						drain_q <= '0;
					end
					second_q <= (i != 16'd0) && (j != 10'd0) && j_last;
					if (j_last) begin
						col_q <= '0;
						if (i >= eff_h - 16'd1) begin
							done_q <= 1'b1;
							row_q <= i;
						end else begin
							row_q <= i + 16'd1;
						end
					end else begin
						col_q <= j + 10'd1;
						row_q <= i;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		second_job_q.row  <= i - 16'd1;
		second_job_q.col  <= j;
		second_job_q.lim  <= i;
		second_job_q.last <= 1'b0;
	end

	a_second_once: assert property (@(posedge clk) disable iff (!arst_n)
		second_q |=> !second_q) else $error("second job repeated");
	a_no_take_second: assert property (@(posedge clk) disable iff (!arst_n)
		second_q |-> full) else $error("item taken during second job");

endmodule

/* src/bb3_back.sv */
// Back end of the box blur: reads the nine taps of the 3x3 window from the
// line store, then divides and emits a result. Depends on bb3_pkg.
module bb3_back import bb3_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              job_valid,
	input  job_t              job,
	output logic              job_room,
	output logic              busy,
	input  logic [10:0]       eff_w,
	input  logic [15:0]       eff_h,
	output logic              rd_en,
	output logic [AddrW-1:0]  rd_addr,
	input  logic [23:0]       rd_data,
	input  logic              wr_en,
	output logic              empty,
	input  logic              pop,
	output out_item_t         res
);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_READ = 4'b0010,
		ST_DIV  = 4'b0100,
		ST_OUT  = 4'b1000
	} st_t;

	st_t         st_q;
	job_t        q_mem [QDepth];
	logic [QPtrW:0] wp_q, rp_q;
	job_t        cur_q;
	logic [3:0]  k_q;        // window tap 0..8 to issue, 9 once all are issued
	logic        rd_pend_s1;
	logic [11:0] sr_q, sg_q, sb_q;
	logic [3:0]  cnt_q;
	logic [4:0]  dk_q;
	logic [13:0] rr_q, rg_q, rb_q;
	logic [7:0]  qr_q, qg_q, qb_q;
	out_item_t   out_q;
	logic        full_q;
	logic [1:0]  dr, dc;
	logic signed [17:0] n;
	logic signed [11:0] m;
	logic        tap_ok;
	logic [4:0]  den;

	assign job_room = (wp_q - rp_q) <= (QPtrW+1)'(QDepth - 2);
	assign busy = (wp_q != rp_q) || (st_q != ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			wp_q <= '0;
		else if (job_valid)
			wp_q <= wp_q + 1'b1;
	end
	always_ff @(posedge clk) begin
		if (job_valid)
			q_mem[wp_q[QPtrW-1:0]] <= job;
	end

	always_comb begin
		dr = (k_q >= 4'd6) ? 2'd2 : (k_q >= 4'd3) ? 2'd1 : 2'd0;
		dc = 2'(k_q - 4'(dr) * 4'd3);
		n = $signed({2'b0, cur_q.row}) + $signed(18'(dr)) - 18'sd1;
		m = $signed({2'b0, cur_q.col}) + $signed(12'(dc)) - 12'sd1;
		tap_ok = (n >= 0) && (n < $signed({2'b0, eff_h})) &&
			(n <= $signed({2'b0, cur_q.lim})) && (m >= 0) &&
			(m < $signed({1'b0, eff_w}));
	end
	// the front end writes in the same cycle only for a later pixel; hold off
	// to keep the single read port clear of it
	assign rd_en = (st_q == ST_READ) && tap_ok && !wr_en;
	assign rd_addr = AddrW'({slot3(n[16:0]), m[9:0]});
	assign den = {cnt_q, 1'b0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			rp_q <= '0;
			full_q <= 1'b0;
			rd_pend_s1 <= 1'b0;
		end else begin
			rd_pend_s1 <= 1'b0;
			if (pop && full_q)
				full_q <= 1'b0;
			case (st_q)
				ST_IDLE: begin
					if (wp_q != rp_q) begin
						rp_q <= rp_q + 1'b1;
						st_q <= ST_READ;
					end
				end
				ST_READ: begin
					if (k_q == 4'd9) begin
						if (!rd_pend_s1)
							st_q <= ST_DIV;
					end else if (!tap_ok || !wr_en) begin
						rd_pend_s1 <= tap_ok;
					end
				end
				ST_DIV: begin
					if (dk_q == 5'd0)
						st_q <= ST_OUT;
				end
				ST_OUT: begin
					if (!full_q || pop) begin
						full_q <= 1'b1;
						st_q <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			ST_IDLE: begin
				cur_q <= q_mem[rp_q[QPtrW-1:0]];
				k_q <= '0;
				sr_q <= '0; sg_q <= '0; sb_q <= '0; cnt_q <= '0;
			end
			ST_READ: begin
				if (k_q != 4'd9 && (!tap_ok || !wr_en)) begin
					k_q <= k_q + 4'd1;
					if (tap_ok)
						cnt_q <= cnt_q + 4'd1;
				end
				if (rd_pend_s1) begin
					sr_q <= sr_q + 12'(rd_data[23:16]);
					sg_q <= sg_q + 12'(rd_data[15:8]);
					sb_q <= sb_q + 12'(rd_data[7:0]);
				end
				dk_q <= 5'd8;
			end
			ST_DIV: begin
				// restoring division, 8 quotient bits
				if (dk_q == 5'd8) begin
					rr_q <= 14'({sr_q, 1'b0} + 13'(cnt_q));
					rg_q <= 14'({sg_q, 1'b0} + 13'(cnt_q));
					rb_q <= 14'({sb_q, 1'b0} + 13'(cnt_q));
					qr_q <= '0; qg_q <= '0; qb_q <= '0;
					dk_q <= 5'd7 | 5'h10;
				end else begin
					if (rr_q >= (14'(den) << dk_q[2:0])) begin
						rr_q <= rr_q - (14'(den) << dk_q[2:0]);
						qr_q[dk_q[2:0]] <= 1'b1;
					end
					if (rg_q >= (14'(den) << dk_q[2:0])) begin
						rg_q <= rg_q - (14'(den) << dk_q[2:0]);
						qg_q[dk_q[2:0]] <= 1'b1;
					end
					if (rb_q >= (14'(den) << dk_q[2:0])) begin
						rb_q <= rb_q - (14'(den) << dk_q[2:0]);
						qb_q[dk_q[2:0]] <= 1'b1;
					end
					dk_q <= (dk_q[2:0] == 3'd0) ? 5'd0 : dk_q - 5'd1;
				end
			end
			ST_OUT: begin
				if (!full_q || pop) begin
					out_q.out_red   <= (cnt_q == 4'd0) ? 8'd0 : qr_q;
					out_q.out_green <= (cnt_q == 4'd0) ? 8'd0 : qg_q;
					out_q.out_blue  <= (cnt_q == 4'd0) ? 8'd0 : qb_q;
					out_q.out_row   <= cur_q.row;
					out_q.out_col   <= cur_q.col;
					out_q.frame_last <= cur_q.last;
				end
			end
			default: ;
		endcase
	end

	assign empty = ~full_q;
	assign res = out_q;

	a_q_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(wp_q - rp_q) <= (QPtrW+1)'(QDepth)) else $error("job queue overflow");
	a_cnt_max: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 4'd9) else $error("window count above nine");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(full_q && !pop) |=> full_q) else $error("result lost");

endmodule

/* src/box_blur_3x3_edge_aware.sv */
// Top level of the 3x3 edge-aware box blur.
// Depends on bb3_pkg, bb3_front, bb3_back.
//
// Input channel: push/full, payload in (cmd, RGB). A transfer happens when
// push is high and full is low. cmd 0 is a frame pixel in raster order,
// cmd 1 a drain step giving one last-row result after the frame.
// Result channel: empty/pop; the oldest result sits on res while empty is
// low and moves on a pop transfer.
// Configuration: cfg_we with cfg_idx/cfg_data writes frame_width (0) or
// frame_height (1) at once; write only while idle.
// Results lag the input by one row. A blur job holds the back end through
// a dequeue, the line-store reads (nine taps on one read port, then a wait
// for the last tap to land), restoring division and the load of the result
// register; a pixel write delays a pending tap.
// Each row end after the first issues two jobs if width > 1. A four-entry
// job queue lets the front take pixels within a row meanwhile; an item at
// column 0 (row or frame start, drain steps) waits until the back end is idle.
// Reset clears counters and queues; the line store is not cleared.
// A stalled receiver holds the result register; the back end, then the queue
// fill and full rises.
module box_blur_3x3_edge_aware import bb3_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  in_item_t    in,
	output logic        empty,
	input  logic        pop,
	output out_item_t   res,
	input  logic        cfg_we,
	input  logic        cfg_idx,
	input  logic [15:0] cfg_data
);

	logic [10:0] width_q;
	logic [15:0] height_q;
	logic [10:0] eff_w;
	logic [15:0] eff_h;
	logic              wr_en, rd_en, job_valid, job_room, busy;
	logic [AddrW-1:0]  wr_addr, rd_addr;
	logic [23:0]       wr_data, rd_data_q;
	job_t              job;
	logic [23:0]       store [3 * MaxWidth];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= 11'd640;
			height_q <= 16'd480;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_idx))
				CFG_WIDTH:  width_q <= cfg_data[10:0];
				CFG_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		eff_w = width_q;
		if (eff_w == 11'd0)
			eff_w = 11'd1;
		if (eff_w > 11'(MaxWidth))
			eff_w = 11'(MaxWidth);
		eff_h = (height_q == 16'd0) ? 16'd1 : height_q;
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			store[wr_addr] <= wr_data;
		if (rd_en)
			rd_data_q <= store[rd_addr];
	end

	bb3_front u_front (
		.clk, .arst_n, .push, .full, .item(in), .eff_w, .eff_h,
		.wr_en, .wr_addr, .wr_data, .job_valid, .job, .job_room, .busy
	);

	bb3_back u_back (
		.clk, .arst_n, .job_valid, .job, .job_room, .busy, .eff_w, .eff_h,
		.rd_en, .rd_addr, .rd_data(rd_data_q), .wr_en, .empty, .pop, .res
	);

endmodule

/* tb/bb3_checker.sv */
// Checker for the 3x3 edge-aware box blur: watches the config port and both
// queue channels, predicts each blurred pixel and compares it field by field.
// Depends on bb3_pkg.
`timescale 1ns / 100ps

module bb3_checker import bb3_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  logic        full,
	input  in_item_t    in,
	input  logic        empty,
	input  logic        pop,
	input  out_item_t   res,
	input  logic        cfg_we,
	input  logic        cfg_idx,
	input  logic [15:0] cfg_data,
	output int          fails,
	output int          pending
);

	bit [23:0]   rows_px [0:3*MaxWidth-1];
	bit [10:0]   width_reg;
	bit [15:0]   height_reg;
	int          cur_row, cur_col, drain_pos;
	bit          frame_done;
	out_item_t   blurred_q[$];

	function automatic int eff_w();
		if (width_reg == 0) return 1;
		if (width_reg > MaxWidth) return MaxWidth;
		return width_reg;
	endfunction

	function automatic int eff_h();
		return (height_reg == 0) ? 1 : height_reg;
	endfunction

	// Mean over the in-frame neighbours; rows above lim are not yet in store.
	function automatic out_item_t blur(int r, int c, int lim, bit last);
		int        sr, sg, sb, cnt, n, m;
		bit [23:0] px;
		out_item_t o;
		sr = 0; sg = 0; sb = 0; cnt = 0;
		for (int dr = -1; dr <= 1; dr++) begin
			n = r + dr;
			if (n < 0 || n >= eff_h() || n > lim)
				continue;
			for (int dc = -1; dc <= 1; dc++) begin
				m = c + dc;
				if (m < 0 || m >= eff_w())
					continue;
				px = rows_px[(n % 3) * MaxWidth + m];
				sr += px[23:16];
				sg += px[15:8];
				sb += px[7:0];
				cnt++;
			end
		end
		if (cnt == 0) begin
			o.out_red = 0; o.out_green = 0; o.out_blue = 0;
		end else begin
			o.out_red   = 8'((2 * sr + cnt) / (2 * cnt));
			o.out_green = 8'((2 * sg + cnt) / (2 * cnt));
			o.out_blue  = 8'((2 * sb + cnt) / (2 * cnt));
		end
		o.out_row    = 16'(r);
		o.out_col    = 10'(c);
		o.frame_last = last;
		return o;
	endfunction

	task automatic take_item(in_item_t it);
		int w, h, i, j;
		w = eff_w();
		h = eff_h();
		if (it.cmd) begin
			if (!frame_done || drain_pos >= w)
				return;
			blurred_q.push_back(blur(cur_row, drain_pos, cur_row, drain_pos == w - 1));
			drain_pos++;
			return;
		end
		if (frame_done) begin
			frame_done = 0;
			cur_row = 0;
			cur_col = 0;
			drain_pos = 0;
		end
		i = cur_row;
		j = cur_col;
		rows_px[(i % 3) * MaxWidth + j] = {it.in_red, it.in_green, it.in_blue};
		if (i >= 1) begin
			if (j >= 1)
				blurred_q.push_back(blur(i - 1, j - 1, i, 0));
			if (j >= w - 1)
				blurred_q.push_back(blur(i - 1, j, i, 0));
		end
		if (j >= w - 1) begin
			cur_col = 0;
			if (i >= h - 1)
				frame_done = 1;
			else
				cur_row = (i + 1) & 16'hFFFF;
		end else begin
			cur_col = (j + 1) & 10'h3FF;
		end
	endtask

	task automatic check_field(string name, int exp_v, int act_v);
		if (exp_v != act_v) begin
			$error("%s expected %0d got %0d", name, exp_v, act_v);
			fails++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		out_item_t e;
		if (!arst_n) begin
			width_reg  = 11'd640;
			height_reg = 16'd480;
			cur_row = 0; cur_col = 0; drain_pos = 0;
			frame_done = 0;
			blurred_q.delete();
		end else begin
			if (cfg_we) begin
				if (cfg_idx == CFG_WIDTH)
					width_reg = cfg_data[10:0];
				else
					height_reg = cfg_data;
			end
			if (push && !full)
				take_item(in);
			if (pop && !empty) begin
				if (blurred_q.size() == 0) begin
					$error("result transfer with nothing expected (row %0d col %0d)",
						res.out_row, res.out_col);
					fails++;
				end else begin
					e = blurred_q.pop_front();
					check_field("out_red", e.out_red, res.out_red);
					check_field("out_green", e.out_green, res.out_green);
					check_field("out_blue", e.out_blue, res.out_blue);
					check_field("out_row", e.out_row, res.out_row);
					check_field("out_col", e.out_col, res.out_col);
					check_field("frame_last", e.frame_last, res.frame_last);
				end
			end
		end
		pending = blurred_q.size();
	end

	initial begin
		fails = 0;
		pending = 0;
	end

endmodule

/* tb/box_blur_3x3_edge_aware_tb.sv */
// Top of the box blur testbench: clock, reset, stimulus, stalls and verdict.
// Depends on bb3_pkg, bb3_checker and the box_blur_3x3_edge_aware RTL.
`timescale 1ns / 100ps

module box_blur_3x3_edge_aware_tb import bb3_pkg::*;;

	localparam int StallLimit = 4000;
	localparam int SettleCycles = 60;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        push = 0;
	logic        full;
	in_item_t    in = '0;
	logic        empty;
	logic        pop = 0;
	out_item_t   res;
	logic        cfg_we = 0;
	logic        cfg_idx = CFG_WIDTH;
	logic [15:0] cfg_data = '0;

	int  fails, pending;
	bit  in_fire;
	int  idle_cycles;
	int  send_gap_pct, recv_stall_pct;
	bit  hold_req;
	int  pixels_sent;

	always #1 clk = ~clk;

	box_blur_3x3_edge_aware dut (
		.clk, .arst_n, .push, .full, .in, .empty, .pop, .res,
		.cfg_we, .cfg_idx, .cfg_data
	);

	bb3_checker chk (
		.clk, .arst_n, .push, .full, .in, .empty, .pop, .res,
		.cfg_we, .cfg_idx, .cfg_data, .fails, .pending
	);

	// Pre-edge view of the input handshake, read by the driver at the next fall.
	always @(posedge clk)
		in_fire <= push && !full;

	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty) || cfg_we)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= StallLimit) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// Receiver: random stalls, plus one long hold-off on request.
	initial begin
		forever begin
			@(negedge clk);
			if (hold_req) begin
				pop <= 0;
				repeat (300) @(negedge clk);
				hold_req = 0;
			end else begin
				pop <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	task automatic put(bit cmd, bit [7:0] r, bit [7:0] g, bit [7:0] b);
		while ($urandom_range(99) < send_gap_pct) begin
			push <= 0;
			@(negedge clk);
		end
		push <= 1;
		in <= '{cmd: cmd, in_red: r, in_green: g, in_blue: b};
		@(negedge clk);
		while (!in_fire)
			@(negedge clk);
		if (!cmd)
			pixels_sent++;
	endtask

	task automatic quiesce();
		push <= 0;
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
		repeat (SettleCycles) @(negedge clk);
	endtask

	task automatic set_size(int w, int h);
		cfg_we <= 1;
		cfg_idx <= CFG_WIDTH;
		cfg_data <= 16'(w);
		@(negedge clk);
		cfg_idx <= CFG_HEIGHT;
		cfg_data <= 16'(h);
		@(negedge clk);
		cfg_we <= 0;
	endtask

	// Pixels of a w x h frame, then some drain steps. extremes: channels 0/255; noise: one stray drain mid-frame.
	task automatic run_frame(int w, int h, int drains, bit extremes, bit noise);
		int spot;
		spot = noise ? $urandom_range(w * h - 1) : -1;
		for (int k = 0; k < w * h; k++) begin
			if (k == spot)
				put(1, 8'($urandom), 8'($urandom), 8'($urandom));
			if (extremes)
				put(0, {8{1'($urandom_range(1))}}, {8{1'($urandom_range(1))}},
					{8{1'($urandom_range(1))}});
			else
				put(0, 8'($urandom), 8'($urandom), 8'($urandom));
		end
		for (int k = 0; k < drains; k++)
			put(1, 8'($urandom), 8'($urandom), 8'($urandom));
	endtask

	initial begin
		int w, h, goal;
		send_gap_pct = 0;
		recv_stall_pct = 0;
		hold_req = 0;
		pixels_sent = 0;
		idle_cycles = 0;
		repeat (11) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// Directed: early drain, 3x3 of mostly extreme values partly drained, then a new frame
		// with a stray drain mid-frame and drains past the width.
		put(1, 8'hFF, 8'hFF, 8'hFF);
		quiesce();
		set_size(3, 3);
		put(0, 8'hFF, 8'hFF, 8'hFF); put(0, 8'h00, 8'h00, 8'h00); put(0, 8'hFF, 8'h00, 8'hFF);
		put(0, 8'h00, 8'hFF, 8'h00); put(0, 8'hFF, 8'hFF, 8'hFF); put(0, 8'h01, 8'h80, 8'h7F);
		put(0, 8'hFF, 8'hFF, 8'hFF); put(0, 8'h00, 8'h00, 8'h00); put(0, 8'hFE, 8'h01, 8'hFF);
		put(1, 8'h00, 8'h00, 8'h00); put(1, 8'h00, 8'h00, 8'h00);
		quiesce();
		set_size(3, 2);
		run_frame(3, 2, 4, 1, 1);
		quiesce();

		// Size extremes: zero sizes, one pixel, tallest height cut short by a smaller height.
		set_size(0, 0);
		run_frame(1, 1, 2, 0, 0);
		quiesce();
		set_size(1, 1);
		run_frame(1, 1, 1, 1, 0);
		quiesce();
		set_size(4, 65535);
		run_frame(4, 3, 0, 0, 0);
		quiesce();
		set_size(4, 4);   // row 3 now closes the frame
		run_frame(4, 1, 4, 0, 0);
		quiesce();

		// Random frames under each idling pattern.
		for (int ph = 0; ph < 4; ph++) begin
			send_gap_pct   = (ph == 1) ? 81 : (ph == 3) ? 7 : 0;
			recv_stall_pct = (ph == 2) ? 81 : (ph == 3) ? 7 : 0;
			goal = pixels_sent + 100;
			if (ph == 0) begin
				set_size(8, 5);
				hold_req = 1;   // block fills while the sender keeps going
				run_frame(8, 5, 8, 0, 0);
				quiesce();
			end
			while (pixels_sent < goal) begin
				w = ($urandom_range(9) == 0) ? 1 : $urandom_range(1, 8);
				h = ($urandom_range(9) == 0) ? 1 : $urandom_range(1, 5);
				set_size(w, h);
				run_frame(w, h,
					($urandom_range(4) == 0) ? $urandom_range(0, w + 1)
						: w + $urandom_range(0, 1),
					$urandom_range(4) == 0, $urandom_range(9) == 0);
				quiesce();
			end
		end

		push <= 0;
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
		repeat (SettleCycles) @(negedge clk);
		if (fails == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

/* sim.f */
src/bb3_pkg.sv
src/bb3_front.sv
src/bb3_back.sv
src/box_blur_3x3_edge_aware.sv
tb/bb3_checker.sv
tb/box_blur_3x3_edge_aware_tb.sv
